FILE: src/psso_pkg.sv
package psso_pkg;

  // Core sizes
  localparam int PHASE_BITS  = 32;
  localparam int TABLE_DEPTH = 1024;
  localparam int SAMPLE_BITS = 16;

  localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
  localparam int QBITS       = IDX_BITS - 2;
  localparam int QUARTER     = TABLE_DEPTH / 4;
  localparam int QTAB_DEPTH  = QUARTER + 1;
  localparam int QIDX_W      = QBITS + 1;
  localparam int MAG_W       = SAMPLE_BITS - 1;

  // Config port
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int AMP_W       = 16;
  localparam int PAN_W       = 17;
  localparam int FRAMES_W    = 13;
  localparam int CNT_BITS    = 12;

  localparam logic [PAN_W-1:0]    PAN_ONE    = PAN_W'(65536);
  localparam logic [FRAMES_W-1:0] MAX_FRAMES = FRAMES_W'(4096);

  // Reset values of the config registers
  localparam logic [PHASE_BITS-1:0] RST_PHASE_INC = PHASE_BITS'(42949673);
  localparam logic [AMP_W-1:0]      RST_AMPLITUDE = AMP_W'(32768);
  localparam logic [PAN_W-1:0]      RST_PAN       = PAN_W'(32768);
  localparam logic [FRAMES_W-1:0]   RST_FRAMES    = FRAMES_W'(512);

  // State memory: phase word and frame count word
  localparam int STATE_DEPTH = 2;
  localparam int STATE_AW    = $clog2(STATE_DEPTH);
  localparam int STATE_W     = PHASE_BITS;
  localparam logic [STATE_AW-1:0] ADDR_PHASE = STATE_AW'(0);
  localparam logic [STATE_AW-1:0] ADDR_COUNT = STATE_AW'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_INC     = 2'd0,
    REG_AMPLITUDE     = 2'd1,
    REG_PAN           = 2'd2,
    REG_BUFFER_FRAMES = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PHASE,
    ST_COUNT,
    ST_LEFT,
    ST_RIGHT
  } state_t;

  typedef struct packed {
    logic              lookup;
    logic [QIDX_W-1:0] qaddr;
    logic              neg;
    logic              mul_amp;
    logic              mul_left;
  } scale_ctrl_t;

  typedef struct packed {
    logic [MAG_W-1:0] left_mag;
    logic [MAG_W-1:0] right_mag;
    logic             neg;
  } scale_res_t;

  // Quarter-wave sine table, degree-9 Taylor in Q2.30, truncated products
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;
  localparam logic [63:0] PEAK    = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
  localparam logic [63:0] C1 = 64'd1686629713;
  localparam logic [63:0] C3 = 64'd693598668;
  localparam logic [63:0] C5 = 64'd85569306;
  localparam logic [63:0] C7 = 64'd5026995;
  localparam logic [63:0] C9 = 64'd172272;

  typedef logic [MAG_W-1:0] qsine_table_t [QTAB_DEPTH];

  function automatic qsine_table_t build_qsine();
    qsine_table_t tab;
    logic [63:0]  u;
    logic [63:0]  u2;
    logic [63:0]  p;
    logic [63:0]  m;
    for (int k = 0; k < QTAB_DEPTH; k++) begin
      u  = 64'(k) << (32 - IDX_BITS);
      u2 = (u * u) >> 30;
      p  = C7 - ((u2 * C9) >> 30);
      p  = C5 - ((u2 * p) >> 30);
      p  = C3 - ((u2 * p) >> 30);
      p  = C1 - ((u2 * p) >> 30);
      p  = (u * p) >> 30;
      m  = (p * PEAK + (Q30_ONE >> 1)) >> 30;
      tab[k] = (m > PEAK) ? PEAK[MAG_W-1:0] : m[MAG_W-1:0];
    end
    return tab;
  endfunction

  localparam qsine_table_t QSINE_TABLE = build_qsine();

endpackage

FILE: src/psso_ram.sv
module psso_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/psso_scale.sv
module psso_scale (
  input  logic                       clk,
  input  psso_pkg::scale_ctrl_t      ctrl,
  input  logic [psso_pkg::AMP_W-1:0] amplitude,
  input  logic [psso_pkg::PAN_W-1:0] pan,
  output psso_pkg::scale_res_t       res
);
  import psso_pkg::*;

  logic [MAG_W-1:0]       mag;
  logic                   neg;
  logic [MAG_W-1:0]       w;
  logic [MAG_W-1:0]       left_mag;
  logic [MAG_W-1:0]       op_a;
  logic [PAN_W-1:0]       op_b;
  logic [MAG_W+PAN_W-1:0] prod;
  logic [MAG_W-1:0]       prod_q;

  // one shared multiplier: gain, then left pan, then right pan
  always_comb begin
    op_a = ctrl.mul_amp ? mag : w;
    if (ctrl.mul_amp) begin
      op_b = {1'b0, amplitude};
    end else if (ctrl.mul_left) begin
      op_b = PAN_ONE - pan;
    end else begin
      op_b = pan;
    end
    prod   = (MAG_W + PAN_W)'(op_a) * (MAG_W + PAN_W)'(op_b);
    prod_q = prod[MAG_W+15:16];
  end

  always_ff @(posedge clk) begin
    if (ctrl.lookup) begin
      mag <= QSINE_TABLE[ctrl.qaddr];
      neg <= ctrl.neg;
    end
    if (ctrl.mul_amp) begin
      w <= prod_q;
    end
    if (ctrl.mul_left) begin
      left_mag <= prod_q;
    end
  end

  assign res.left_mag  = left_mag;
  assign res.right_mag = prod_q;
  assign res.neg       = neg;

endmodule

FILE: src/stereo_panned_sine_oscillator.sv
// Stereo panned sine oscillator, phase-accumulator (NCO) form.
//
// Input channel (in_valid / in_stall): one transfer is one tick and carries
// restart_phase; set, it clears phase and frame count before this frame.
// Output channel (out_valid / out_stall): one transfer per tick with the
// left and right Q1.15 samples and last_in_buffer.
// Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): always ready;
// index 0 phase increment, 1 amplitude, 2 pan, 3 buffer frames. Write only
// while no tick is in flight.
//
// A taken tick steps through ST_PHASE, ST_COUNT, ST_LEFT and ST_RIGHT,
// which loads its frame into the output register. The steps follow the
// state memory walk (phase read/write, count read/write) and the one
// shared multiplier used three times (gain, left pan, right pan).
// Reset: registers take their defaults, then a clearing pass zeroes the
// state memory; in_stall is high during that pass.
// A stalled output holds its frame; the sequencer waits in its last step,
// and the next tick is taken as soon as the output register frees up.
module stereo_panned_sine_oscillator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            restart_phase,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [psso_pkg::SAMPLE_BITS-1:0] left_sample,
  output logic signed [psso_pkg::SAMPLE_BITS-1:0] right_sample,
  output logic                            last_in_buffer,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [psso_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psso_pkg::CFG_DATA_W-1:0] cfg_data
);
  import psso_pkg::*;

  // config registers
  logic [PHASE_BITS-1:0] phase_inc;
  logic [AMP_W-1:0]      amplitude;
  logic [PAN_W-1:0]      pan_position;
  logic [FRAMES_W-1:0]   buffer_frames;

  // sequencer
  state_t               state;
  state_t               state_next;
  logic [STATE_AW-1:0]  clr_addr;
  logic                 restart;
  logic                 last;

  // state memory port
  logic                 ram_we;
  logic [STATE_AW-1:0]  ram_waddr;
  logic [STATE_W-1:0]   ram_wdata;
  logic [STATE_AW-1:0]  ram_raddr;
  logic [STATE_W-1:0]   ram_rdata;

  scale_ctrl_t          ctrl;
  scale_res_t           res;

  logic                 out_free;
  logic                 out_load;
  logic                 in_accept;

  // phase step
  logic [PHASE_BITS-1:0] phase;
  logic [IDX_BITS-1:0]   tab_idx;
  logic [QBITS-1:0]      quad_pos;
  logic [QIDX_W-1:0]     qaddr;

  // frame count step
  logic [CNT_BITS-1:0]   cnt;
  logic [CNT_BITS-1:0]   cnt_next;
  logic [FRAMES_W-1:0]   frames;
  logic                  last_next;
  logic [PAN_W-1:0]      pan_sat;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_inc     <= RST_PHASE_INC;
      amplitude     <= RST_AMPLITUDE;
      pan_position  <= RST_PAN;
      buffer_frames <= RST_FRAMES;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PHASE_INC:     phase_inc     <= PHASE_BITS'(cfg_data);
        REG_AMPLITUDE:     amplitude     <= cfg_data[AMP_W-1:0];
        REG_PAN:           pan_position  <= cfg_data[PAN_W-1:0];
        REG_BUFFER_FRAMES: buffer_frames <= cfg_data[FRAMES_W-1:0];
        default: ;
      endcase
    end
  end

  // pan above full right saturates
  assign pan_sat = (pan_position > PAN_ONE) ? PAN_ONE : pan_position;

  // phase word arrives in ST_PHASE; restart overrides it
  always_comb begin
    phase    = restart ? '0 : ram_rdata[PHASE_BITS-1:0];
    tab_idx  = phase[PHASE_BITS-1 -: IDX_BITS];
    quad_pos = tab_idx[QBITS-1:0];
    // odd quadrants read the quarter table mirrored
    qaddr    = tab_idx[QBITS] ? (QIDX_W'(QUARTER) - {1'b0, quad_pos}) : {1'b0, quad_pos};
  end

  // count word arrives in ST_COUNT
  always_comb begin
    cnt = restart ? '0 : ram_rdata[CNT_BITS-1:0];
    if (buffer_frames == '0) begin
      frames = FRAMES_W'(1);
    end else if (buffer_frames > MAX_FRAMES) begin
      frames = MAX_FRAMES;
    end else begin
      frames = buffer_frames;
    end
    last_next = ({1'b0, cnt} >= (frames - FRAMES_W'(1)));
    cnt_next  = last_next ? '0 : cnt + CNT_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + STATE_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      restart <= restart_phase;
    end
    if (state == ST_COUNT) begin
      last <= last_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = ADDR_PHASE;
    ram_wdata  = '0;
    ram_raddr  = ADDR_PHASE;
    ctrl       = '0;
    in_stall   = 1'b1;
    out_load   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        if (clr_addr == ADDR_COUNT) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = ST_PHASE;
        end
      end
      ST_PHASE: begin
        // write back advanced phase, fetch count, look up sine
        ram_we     = 1'b1;
        ram_waddr  = ADDR_PHASE;
        ram_wdata  = STATE_W'(phase + phase_inc);
        ram_raddr  = ADDR_COUNT;
        ctrl.lookup = 1'b1;
        ctrl.qaddr  = qaddr;
        ctrl.neg    = tab_idx[IDX_BITS-1];
        state_next  = ST_COUNT;
      end
      ST_COUNT: begin
        ram_we       = 1'b1;
        ram_waddr    = ADDR_COUNT;
        ram_wdata    = STATE_W'(cnt_next);
        ctrl.mul_amp = 1'b1;
        state_next   = ST_LEFT;
      end
      ST_LEFT: begin
        ctrl.mul_left = 1'b1;
        state_next    = ST_RIGHT;
      end
      ST_RIGHT: begin
        // right product is live here; hold until the output frees up
        if (out_free) begin
          out_load   = 1'b1;
          in_stall   = 1'b0;
          state_next = in_valid ? ST_PHASE : ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  psso_ram #(
    .WIDTH(STATE_W),
    .DEPTH(STATE_DEPTH)
  ) u_state_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  psso_scale u_scale (
    .clk      (clk),
    .ctrl     (ctrl),
    .amplitude(amplitude),
    .pan      (pan_sat),
    .res      (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      left_sample    <= res.neg ? -{1'b0, res.left_mag}  : {1'b0, res.left_mag};
      right_sample   <= res.neg ? -{1'b0, res.right_mag} : {1'b0, res.right_mag};
      last_in_buffer <= last;
    end
  end

endmodule

FILE: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW          = psso_pkg::SAMPLE_BITS;
  localparam int RANDOM_TICKS = 700;  // random ticks after the directed part
  localparam int SETTLE      = 12;    // idle cycles after the last frame
  localparam int IDLE_LIMIT  = 2000;  // cycles with no transfer at all before giving up
  localparam int MAX_REPORTS = 100;   // keep the log short if everything breaks

  // Taylor coefficients of sin(pi/2 * u), magnitudes in Q2.30
  localparam logic [63:0] SIN_K1    = 64'd1686629713;
  localparam logic [63:0] SIN_K3    = 64'd693598668;
  localparam logic [63:0] SIN_K5    = 64'd85569306;
  localparam logic [63:0] SIN_K7    = 64'd5026995;
  localparam logic [63:0] SIN_K9    = 64'd172272;
  localparam logic [63:0] WAVE_PEAK = 64'd32767;
  localparam logic [63:0] Q30_UNIT  = 64'd1 << 30;

  typedef struct {
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
    logic                 last;
  } frame_t;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // DUT stimulus, all known from time zero
  logic                 in_valid      = 1'b0;
  logic                 restart_phase = 1'b0;
  logic                 out_stall     = 1'b0;
  logic                 cfg_valid     = 1'b0;
  psso_pkg::cfg_reg_t   cfg_index     = psso_pkg::REG_PHASE_INC;
  logic [31:0]          cfg_data      = '0;

  logic                 in_stall;
  logic                 out_valid;
  logic signed [SW-1:0] left_sample;
  logic signed [SW-1:0] right_sample;
  logic                 last_in_buffer;
  logic                 cfg_ready;

  stereo_panned_sine_oscillator i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .restart_phase  (restart_phase),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .left_sample    (left_sample),
    .right_sample   (right_sample),
    .last_in_buffer (last_in_buffer),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Oscillator mirror: register copies (reset defaults) and running state
  logic [31:0] inc_reg    = 32'd42949673;
  logic [15:0] amp_reg    = 16'd32768;
  logic [16:0] pan_reg    = 17'd32768;
  logic [12:0] frames_reg = 13'd512;
  logic [31:0] phase_acc  = '0;
  logic [11:0] frame_cnt  = '0;

  frame_t frames_due[$];   // predicted frames, oldest first
  int     errors       = 0;
  int     ticks_sent   = 0;
  int     quiet_cycles = 0;
  bit     in_burst     = 1'b0;  // sender runs with no gaps
  bit     out_burst    = 1'b0;  // receiver never stalls

  // Quarter-wave sine magnitude at Q1.15 peak scale; u is Q2.30 in [0, 1].
  // Horner form, every product truncated, final rounding half up.
  function automatic logic [SW-2:0] sine_magnitude(input logic [63:0] u);
    logic [63:0] u2;
    logic [63:0] acc;
    logic [63:0] m;
    u2  = (u * u) >> 30;
    acc = SIN_K7 - ((u2 * SIN_K9) >> 30);
    acc = SIN_K5 - ((u2 * acc) >> 30);
    acc = SIN_K3 - ((u2 * acc) >> 30);
    acc = SIN_K1 - ((u2 * acc) >> 30);
    acc = (u * acc) >> 30;
    m   = (acc * WAVE_PEAK + (Q30_UNIT >> 1)) >> 30;
    return (m > WAVE_PEAK) ? WAVE_PEAK[SW-2:0] : m[SW-2:0];
  endfunction

  // One tick of the oscillator: returns the frame and advances the mirror.
  function automatic frame_t next_frame(input logic restart);
    logic [9:0]    idx;
    logic [1:0]    quad;
    logic [10:0]   r;
    logic [63:0]   w;
    logic [63:0]   lmag;
    logic [63:0]   rmag;
    logic [16:0]   pan;
    logic [12:0]   frames;
    logic [SW-2:0] mag;
    logic          neg;
    frame_t        f;
    if (restart) begin
      phase_acc = '0;
      frame_cnt = '0;
    end
    // table index is the top 10 phase bits; top two of those pick the quadrant
    idx  = phase_acc[31:22];
    quad = idx[9:8];
    r    = {1'b0, idx[7:0], 2'b00};
    if (quad[0]) begin
      r = 11'd1024 - r;    // falling quadrants mirror the angle
    end
    neg = quad[1];
    mag = sine_magnitude(64'(r) << 20);

    // gain and pan act on the magnitude; sign is restored at the end
    w    = (64'(mag) * 64'(amp_reg)) >> 16;
    pan  = (pan_reg > 17'd65536) ? 17'd65536 : pan_reg;
    lmag = (w * (64'd65536 - 64'(pan))) >> 16;
    rmag = (w * 64'(pan)) >> 16;
    f.left  = neg ? -lmag[SW-1:0] : lmag[SW-1:0];
    f.right = neg ? -rmag[SW-1:0] : rmag[SW-1:0];

    // zero-size buffer acts as one frame, oversize clamps to 4096
    frames = frames_reg;
    if (frames == 13'd0) begin
      frames = 13'd1;
    end else if (frames > 13'd4096) begin
      frames = 13'd4096;
    end
    // a counter already past a lowered buffer size ends the buffer now
    f.last    = ({1'b0, frame_cnt} >= frames - 13'd1);
    frame_cnt = f.last ? 12'd0 : frame_cnt + 12'd1;

    phase_acc = phase_acc + inc_reg;   // wraps mod 2^32
    return f;
  endfunction

  function automatic void flag_mismatch(input string field, input int want, input int got);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  // Sender: random gap, then hold the tick until the transfer happens.
  // in_valid is left high on return so gapless ticks go back to back.
  task automatic send_tick(input logic restart);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid      <= 1'b0;
      restart_phase <= 1'($urandom_range(0, 1));   // junk while idle
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    restart_phase <= restart;
    do @(posedge clk); while (in_stall);
    frames_due.push_back(next_frame(restart));
    ticks_sent++;
  endtask

  // Stop sending and wait until every predicted frame has come out,
  // plus a margin so the block is truly idle for register writes.
  task automatic wait_frames_out();
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One config transfer; the extra edge keeps back-to-back writes clean.
  task automatic write_reg(input psso_pkg::cfg_reg_t which, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (which)
      psso_pkg::REG_PHASE_INC:     inc_reg    = value;
      psso_pkg::REG_AMPLITUDE:     amp_reg    = value[15:0];
      psso_pkg::REG_PAN:           pan_reg    = value[16:0];
      psso_pkg::REG_BUFFER_FRAMES: frames_reg = value[12:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Receiver: compare each transfer against the oldest prediction, then
  // draw a stall for the next stretch. Stalls also land on idle cycles.
  initial begin : result_checker
    frame_t want;
    int     hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (frames_due.size() == 0) begin
          errors++;
          $display("%0t: frame with nothing expected, actual L=%0d R=%0d last=%0b",
                   $time, left_sample, right_sample, last_in_buffer);
        end else begin
          want = frames_due.pop_front();
          if (left_sample !== want.left) begin
            flag_mismatch("left_sample", want.left, left_sample);
          end
          if (right_sample !== want.right) begin
            flag_mismatch("right_sample", want.right, right_sample);
          end
          if (last_in_buffer !== want.last) begin
            flag_mismatch("last_in_buffer", want.last, last_in_buffer);
          end
        end
        hold = out_burst ? 0 : $urandom_range(0, 14);
      end
      out_stall <= (hold > 0);
      if (hold > 0) begin
        hold--;
      end
    end
  end

  // Watchdog: any transfer on any channel counts as progress
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    do @(posedge clk); while (quiet_cycles < IDLE_LIMIT);
    $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Reset defaults, first frame from phase zero, then a restart after two plain ticks
  task automatic test_reset_defaults();
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    wait_frames_out();
  endtask

  // Quarter-turn steps: zero, positive peak, negative zero, negative peak,
  // wrap back to zero. Full gain, full left.
  task automatic test_quadrant_peaks();
    write_reg(psso_pkg::REG_PHASE_INC, 32'h4000_0000);
    write_reg(psso_pkg::REG_AMPLITUDE, 32'h0000_FFFF);
    write_reg(psso_pkg::REG_PAN, 32'd0);
    send_tick(1'b1);
    repeat (4) send_tick(1'b0);
    wait_frames_out();
  endtask

  // Full right, then a pan above unity (must saturate), then zero gain
  task automatic test_pan_extremes();
    write_reg(psso_pkg::REG_PAN, 32'd65536);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    wait_frames_out();
    write_reg(psso_pkg::REG_PAN, 32'hFFFF_FFFF);   // upper bits dropped, 0x1FFFF left
    send_tick(1'b1);
    send_tick(1'b0);
    wait_frames_out();
    write_reg(psso_pkg::REG_AMPLITUDE, 32'hFFFF_0000);
    send_tick(1'b1);
    wait_frames_out();
  endtask

  // Buffer size zero, oversize, and a size lowered below the running count.
  // All-ones increment exercises the phase wrap.
  task automatic test_buffer_limits();
    write_reg(psso_pkg::REG_BUFFER_FRAMES, 32'd0);
    write_reg(psso_pkg::REG_PHASE_INC, 32'hFFFF_FFFF);
    write_reg(psso_pkg::REG_AMPLITUDE, 32'd1);
    repeat (3) send_tick(1'b0);
    wait_frames_out();
    write_reg(psso_pkg::REG_BUFFER_FRAMES, 32'd8191);
    send_tick(1'b1);
    send_tick(1'b0);
    wait_frames_out();
    write_reg(psso_pkg::REG_BUFFER_FRAMES, 32'd512);
    write_reg(psso_pkg::REG_AMPLITUDE, 32'd40000);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    wait_frames_out();
    write_reg(psso_pkg::REG_BUFFER_FRAMES, 32'd2);  // count is 4 here
    send_tick(1'b0);
    wait_frames_out();
  endtask

  // Random settings per phase, then a run of ticks with rare restarts.
  // Small buffers dominate so buffer ends come often.
  task automatic test_random_traffic();
    int          first;
    logic [31:0] value;
    first = ticks_sent;
    while (ticks_sent - first < RANDOM_TICKS) begin
      wait_frames_out();
      in_burst  = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);

      case ($urandom_range(0, 4))
        0:       value = 32'd0;
        1:       value = 32'hFFFF_FFFF;
        2:       value = $urandom_range(0, 32'h00FF_FFFF);          // slow sweep
        3:       value = {10'($urandom_range(0, 1023)), 22'd0};     // whole table steps
        default: value = $urandom;
      endcase
      write_reg(psso_pkg::REG_PHASE_INC, value);

      value = $urandom;   // upper bits are don't-care in the register
      case ($urandom_range(0, 3))
        0:       value[15:0] = 16'd0;
        1:       value[15:0] = 16'hFFFF;
        default: ;
      endcase
      write_reg(psso_pkg::REG_AMPLITUDE, value);

      value = $urandom;
      case ($urandom_range(0, 5))
        0:       value[16:0] = 17'd0;
        1:       value[16:0] = 17'd65536;
        2:       value[16:0] = 17'($urandom_range(65537, 131071));
        default: value[16:0] = 17'($urandom_range(0, 65536));
      endcase
      write_reg(psso_pkg::REG_PAN, value);

      value = $urandom;
      case ($urandom_range(0, 7))
        0:       value[12:0] = 13'd0;
        1:       value[12:0] = 13'd4096;
        2:       value[12:0] = 13'($urandom_range(4097, 8191));
        3:       value[12:0] = 13'($urandom_range(1, 4096));
        default: value[12:0] = 13'($urandom_range(1, 16));
      endcase
      write_reg(psso_pkg::REG_BUFFER_FRAMES, value);

      repeat ($urandom_range(10, 50)) send_tick($urandom_range(0, 15) == 0);
    end
    wait_frames_out();
    in_burst  = 1'b0;
    out_burst = 1'b0;
  endtask

  initial begin : sequencer
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_quadrant_peaks();
    test_pan_extremes();
    test_buffer_limits();
    test_random_traffic();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
